// ===== src/fpc_pkg.sv =====
package fpc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_BOX    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        radius;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
  } in_word_t;

  typedef struct packed {
    logic inside_res;
    logic planes_ready;
  } out_word_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_STORE  = 3'd1,
    OP_RAW    = 3'd2,
    OP_SQRT   = 3'd3,
    OP_DIV    = 3'd4,
    OP_DOT    = 3'd5,
    OP_CORNER = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] plane;
    logic [1:0] comp;
    logic [1:0] term;
    logic       first;
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic dist_valid;
    logic dist_pass;
  } dp_stat_t;

endpackage

// ===== src/frustum_plane_cull.sv =====
// Frustum plane culling. A word with start high is taken when busy is low;
// busy stays high until the single result word is shown on out_valid for one
// cycle, and the receiver cannot stall it. A load of element 15 extracts six
// planes with a shared serial square root and a serial divider. A point or
// sphere test runs one multiplier over four terms per plane; a box test
// repeats this for up to eight corners.
module frustum_plane_cull import fpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       capture;
  logic [2:0] corner;

  fpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .command(in_word.command),
    .elem_index(in_word.elem_index), .stat(stat), .busy(busy),
    .capture(capture), .cmd(cmd), .corner(corner), .result(out_word),
    .out_valid(out_valid)
  );

  fpc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .word_in(in_word), .capture(capture),
    .cmd(cmd), .corner(corner), .stat(stat)
  );

endmodule

// ===== src/fpc_sqrt.sv =====
module fpc_sqrt import fpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  // Restoring square root, one result bit per cycle.
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] res_r, res_nxt;
  logic [65:0] acc_r, acc_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [65:0] trial;

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      acc_nxt  = '0;
      rem_nxt  = radicand;
      res_nxt  = '0;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[63:0], rem_r[63:62]};
      rem_nxt = {rem_r[61:0], 2'b00};
      trial   = {32'd0, res_r, 2'b01};
      if (acc_nxt >= trial) begin
        acc_nxt = acc_nxt - trial;
        res_nxt = {res_r[30:0], 1'b1};
      end else begin
        res_nxt = {res_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign root = res_r;

endmodule

// ===== src/fpc_div.sv =====
module fpc_div import fpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] mag,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [56:0] quot
);

  // Restoring division of (mag << F) + divisor/2 by divisor, one bit a cycle.
  localparam int NB = 57;
  logic [NB-1:0] num_r, num_nxt;
  logic [NB-1:0] q_r, q_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [32:0]   sh;

  always_comb begin
    num_nxt  = num_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = '0;
    if (start) begin
      num_nxt  = (NB'(mag) << FRAC_BITS) + NB'(divisor >> 1);
      q_nxt    = '0;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh      = {rem_r[31:0], num_r[NB-1]};
      num_nxt = {num_r[NB-2:0], 1'b0};
      if (sh >= {1'b0, divisor}) begin
        rem_nxt = sh - {1'b0, divisor};
        q_nxt   = {q_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[NB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(NB - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== src/fpc_datapath.sv =====
module fpc_datapath import fpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_word_t word_in,
  input  logic     capture,
  input  dp_cmd_t  cmd,
  input  logic [2:0] corner,
  output dp_stat_t stat
);

  localparam logic signed [63:0] S32MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32MIN = -64'sd2147483648;

  in_word_t           w_r;
  logic signed [31:0] pv_r [16];
  logic signed [31:0] pl_r [24];
  logic signed [31:0] raw_r [4];
  logic [63:0]        ss_r;
  logic [31:0]        len_r;
  logic signed [32:0] cx_r, cy_r, cz_r;
  logic signed [66:0] acc_r;
  logic signed [65:0] prod_r;
  logic               prod_v_r, last_r;
  logic               dv_r, dpass_r;

  // Capture of the input word.
  always_ff @(posedge clk) begin
    if (capture) w_r <= word_in;
  end

  // Matrix store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) pv_r[i] <= '0;
    end else if (cmd.op == OP_STORE) begin
      pv_r[w_r.elem_index] <= w_r.elem_value;
    end
  end

  // Raw plane row: row 3 plus or minus another row, saturated.
  logic [1:0]         prow;
  logic               pneg;
  logic signed [32:0] rsum;
  logic signed [31:0] rsat;
  always_comb begin
    case (cmd.plane)
      3'd0: begin prow = 2'd0; pneg = 1'b0; end
      3'd1: begin prow = 2'd0; pneg = 1'b1; end
      3'd2: begin prow = 2'd1; pneg = 1'b1; end
      3'd3: begin prow = 2'd1; pneg = 1'b0; end
      3'd4: begin prow = 2'd2; pneg = 1'b0; end
      default: begin prow = 2'd2; pneg = 1'b1; end
    endcase
    if (pneg) rsum = 33'(pv_r[{2'd3, cmd.comp}]) - 33'(pv_r[{prow, cmd.comp}]);
    else      rsum = 33'(pv_r[{2'd3, cmd.comp}]) + 33'(pv_r[{prow, cmd.comp}]);
    if (rsum > 33'sd2147483647)       rsat = 32'sh7fffffff;
    else if (rsum < -33'sd2147483648) rsat = 32'sh80000000;
    else                              rsat = rsum[31:0];
  end

  // One squaring per raw component; sum of squares of the normal.
  logic signed [63:0] sq;
  assign sq = rsat * rsat;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RAW) begin
      raw_r[cmd.comp] <= rsat;
      if (cmd.comp == 2'd0)      ss_r <= 64'(sq);
      else if (cmd.comp != 2'd3) ss_r <= ss_r + 64'(sq);
    end
  end

  // Length of the normal.
  logic        sq_done;
  logic [31:0] sq_root;
  fpc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.op == OP_SQRT && cmd.first),
    .radicand(ss_r), .done(sq_done), .root(sq_root)
  );
  always_ff @(posedge clk) begin
    if (sq_done) len_r <= sq_root;
  end

  // Normalization divide of one component.
  logic signed [31:0] rsel;
  logic [31:0]        rmag;
  logic               dv_done;
  logic [56:0]        q;
  logic signed [31:0] qsat;
  assign rsel = raw_r[cmd.comp];
  assign rmag = rsel[31] ? 32'(-33'(rsel)) : rsel;
  fpc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n),
    .start(cmd.op == OP_DIV && cmd.first && len_r != '0),
    .mag(rmag), .divisor(len_r), .done(dv_done), .quot(q)
  );
  always_comb begin
    if (rsel[31]) qsat = (q > 57'd2147483648) ? 32'sh80000000 : 32'(-58'(q));
    else          qsat = (q > 57'd2147483647) ? 32'sh7fffffff : q[31:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 24; i++) pl_r[i] <= '0;
    end else if (cmd.op == OP_DIV && cmd.first && len_r == '0) begin
      pl_r[{cmd.plane, cmd.comp}] <= '0;
    end else if (dv_done) begin
      pl_r[{cmd.plane, cmd.comp}] <= qsat;
    end
  end

  // Corner (or centre) of the tested shape.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CORNER) begin
      if (w_r.command == CMD_BOX) begin
        cx_r <= corner[0] ? 33'(w_r.pos_x) + 33'(w_r.half_x) : 33'(w_r.pos_x) - 33'(w_r.half_x);
        cy_r <= corner[1] ? 33'(w_r.pos_y) + 33'(w_r.half_y) : 33'(w_r.pos_y) - 33'(w_r.half_y);
        cz_r <= corner[2] ? 33'(w_r.pos_z) + 33'(w_r.half_z) : 33'(w_r.pos_z) - 33'(w_r.half_z);
      end else begin
        cx_r <= 33'(w_r.pos_x);
        cy_r <= 33'(w_r.pos_y);
        cz_r <= 33'(w_r.pos_z);
      end
    end
  end

  // Shared multiplier, one term per cycle, then accumulation.
  logic signed [31:0] ca;
  logic signed [32:0] cb;
  always_comb begin
    case (cmd.term)
      2'd0: begin ca = pl_r[{cmd.plane, 2'd0}]; cb = cx_r; end
      2'd1: begin ca = pl_r[{cmd.plane, 2'd1}]; cb = cy_r; end
      2'd2: begin ca = pl_r[{cmd.plane, 2'd2}]; cb = cz_r; end
      default: begin ca = pl_r[{cmd.plane, 2'd3}]; cb = 33'sd1 <<< FRAC_BITS; end
    endcase
  end

  logic signed [66:0] acc_sum;
  logic signed [66:0] fl;
  logic signed [63:0] pl_dist;
  assign acc_sum = acc_r + 67'(prod_r);
  always_comb begin
    fl = acc_sum >>> FRAC_BITS;
    if (fl > 67'(S32MAX))      pl_dist = S32MAX;
    else if (fl < 67'(S32MIN)) pl_dist = S32MIN;
    else                       pl_dist = 64'(fl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      last_r   <= 1'b0;
      dv_r     <= 1'b0;
    end else begin
      prod_v_r <= (cmd.op == OP_DOT);
      last_r   <= (cmd.op == OP_DOT) && cmd.term == 2'd3;
      dv_r     <= prod_v_r && last_r;
    end
    prod_r <= ca * cb;
    if (prod_v_r) acc_r <= last_r ? '0 : acc_sum;
    if (cmd.op == OP_DOT && cmd.term == 2'd0 && !prod_v_r) acc_r <= '0;
    if (prod_v_r && last_r) begin
      if (w_r.command == CMD_SPHERE) dpass_r <= pl_dist > -$signed(64'(w_r.radius));
      else                           dpass_r <= pl_dist > 64'sd0;
    end
  end

  // A plane with a zero-length normal finishes each component at once.
  assign stat.sqrt_done  = sq_done;
  assign stat.div_done   = dv_done || (cmd.op == OP_DIV && len_r == '0);
  assign stat.dist_valid = dv_r;
  assign stat.dist_pass  = dpass_r;

endmodule

// ===== src/fpc_ctrl.sv =====
module fpc_ctrl import fpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] command,
  input  logic [3:0] elem_index,
  input  dp_stat_t   stat,
  output logic       busy,
  output logic       capture,
  output dp_cmd_t    cmd,
  output logic [2:0] corner,
  output out_word_t  result,
  output logic       out_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_STORE, S_RAW, S_SQRT, S_SQW, S_DIV, S_DIVW,
    S_CORNER, S_DOT, S_DRAIN, S_WAIT, S_DONE
  } state_t;

  state_t     state_r;
  logic [2:0] plane_r, corner_r;
  logic [1:0] comp_r, term_r;
  logic [1:0] cmd_r;
  logic       ext_r, valid_r, pass_r, res_r, ov_r;

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.plane = plane_r;
    cmd.comp  = comp_r;
    cmd.term  = term_r;
    case (state_r)
      S_STORE:  cmd.op = OP_STORE;
      S_RAW:    cmd.op = OP_RAW;
      S_SQRT:   begin cmd.op = OP_SQRT; cmd.first = 1'b1; end
      S_DIV:    begin cmd.op = OP_DIV; cmd.first = 1'b1; end
      S_DIVW:   cmd.op = OP_DIV;
      S_CORNER: cmd.op = OP_CORNER;
      S_DOT:    cmd.op = OP_DOT;
      default:  cmd.op = OP_NONE;
    endcase
  end

  assign busy      = state_r != S_IDLE;
  assign capture   = start && !busy;
  assign corner    = corner_r;
  assign out_valid = ov_r;
  assign result    = '{inside_res: res_r, planes_ready: valid_r};

  // Sequencer for loads, plane extraction and the plane tests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= 1'b0;
      ov_r     <= 1'b0;
      res_r    <= 1'b0;
      plane_r  <= '0;
      comp_r   <= '0;
      term_r   <= '0;
      corner_r <= '0;
      cmd_r    <= '0;
      ext_r    <= 1'b0;
      pass_r   <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r    <= command;
            ext_r    <= elem_index == 4'd15;
            plane_r  <= '0;
            comp_r   <= '0;
            term_r   <= '0;
            corner_r <= '0;
            pass_r   <= 1'b1;
            if (command == CMD_LOAD)  state_r <= S_STORE;
            else if (!valid_r) begin
              res_r   <= 1'b0;
              state_r <= S_DONE;
            end else state_r <= S_CORNER;
          end
        end
        S_STORE: begin
          res_r   <= 1'b0;
          state_r <= ext_r ? S_RAW : S_DONE;
        end
        S_RAW: begin
          comp_r <= comp_r + 2'd1;
          if (comp_r == 2'd3) state_r <= S_SQRT;
        end
        S_SQRT: state_r <= S_SQW;
        S_SQW: if (stat.sqrt_done) state_r <= S_DIV;
        S_DIV: state_r <= S_DIVW;
        S_DIVW: begin
          if (stat.div_done) begin
            comp_r <= comp_r + 2'd1;
            if (comp_r != 2'd3) state_r <= S_DIV;
            else if (plane_r == 3'd5) begin
              valid_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              plane_r <= plane_r + 3'd1;
              state_r <= S_RAW;
            end
          end
        end
        S_CORNER: begin
          plane_r <= '0;
          term_r  <= '0;
          pass_r  <= 1'b1;
          state_r <= S_DOT;
        end
        S_DOT: begin
          term_r <= term_r + 2'd1;
          if (term_r == 2'd3) state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (stat.dist_valid) begin
            if (plane_r == 3'd5 || !stat.dist_pass) begin
              if (pass_r && stat.dist_pass) begin
                res_r   <= 1'b1;
                state_r <= S_DONE;
              end else if (cmd_r == CMD_BOX && corner_r != 3'd7) begin
                corner_r <= corner_r + 3'd1;
                state_r  <= S_CORNER;
              end else begin
                res_r   <= 1'b0;
                state_r <= S_DONE;
              end
            end else begin
              plane_r <= plane_r + 3'd1;
              state_r <= S_DOT;
            end
          end
        end
        S_DONE: begin
          ov_r    <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> state_r == S_IDLE) else $error("result strobe outside idle");
  a_res_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && res_r |-> valid_r) else $error("pass reported without planes");
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r) else $error("result strobe held");
`endif

endmodule

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  import fpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB          = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  // Predictor state: the loaded matrix, the extracted planes and the ready flag.
  int   mtx [16];
  int   pln [24];
  bit   pln_ok;

  out_word_t expected_q[$];
  int        mismatches;
  int        fails;
  int        quiet_cycles;
  bit        idle_on;

  frustum_plane_cull i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint sat32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return longint'(v);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Rounded division of one plane component by the normal length.
  function automatic int scale_comp(longint v, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (v < 0) ? longint'(-v) : v;
    q   = ((mag << FB) + (len >> 1)) / len;
    if (v < 0) return (q > 64'd2147483648) ? int'(-64'sd2147483648) : int'(-longint'(q));
    return (q > 64'd2147483647) ? 32'sd2147483647 : int'(q);
  endfunction

  // Six planes from row 3 plus or minus rows 0, 1 and 2.
  function automatic void extract_planes();
    int          row;
    bit          neg;
    longint      raw [4];
    longint unsigned ss;
    longint unsigned len;
    for (int p = 0; p < 6; p++) begin
      row = p / 2;
      neg = (p == 1) || (p == 2) || (p == 5);
      for (int k = 0; k < 4; k++)
        raw[k] = sat32(neg ? longint'(mtx[12+k]) - mtx[4*row+k]
                           : longint'(mtx[12+k]) + mtx[4*row+k]);
      ss = 0;
      for (int k = 0; k < 3; k++) ss += longint'(raw[k] * raw[k]);
      len = isqrt(ss);
      for (int k = 0; k < 4; k++) pln[4*p+k] = (len != 0) ? scale_comp(raw[k], len) : 0;
    end
    pln_ok = 1'b1;
  endfunction

  // Signed distance of a point to one plane, floored and saturated.
  function automatic longint plane_dist(int p, longint x, longint y, longint z);
    logic signed [127:0] a, b, c, d, acc;
    a = pln[4*p]; b = pln[4*p+1]; c = pln[4*p+2]; d = pln[4*p+3];
    acc = a * x + b * y + c * z + (d <<< FB);
    return sat32(acc >>> FB);
  endfunction

  function automatic bit point_inside(longint x, longint y, longint z);
    for (int p = 0; p < 6; p++)
      if (plane_dist(p, x, y, z) <= 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic out_word_t cull_predict(in_word_t w);
    out_word_t r;
    longint    x, y, z, cx, cy, cz, rad;
    x = w.pos_x; y = w.pos_y; z = w.pos_z;
    rad = w.radius;
    r.inside_res = 1'b0;
    if (cmd_t'(w.command) == CMD_LOAD) begin
      mtx[w.elem_index] = w.elem_value;
      if (w.elem_index == 4'd15) extract_planes();
    end else if (pln_ok) begin
      case (cmd_t'(w.command))
        CMD_POINT: begin
          r.inside_res = point_inside(x, y, z);
        end
        CMD_SPHERE: begin
          r.inside_res = 1'b1;
          for (int p = 0; p < 6; p++)
            if (plane_dist(p, x, y, z) <= -rad) r.inside_res = 1'b0;
        end
        default: begin
          for (int c = 0; c < 8 && !r.inside_res; c++) begin
            cx = c[0] ? x + w.half_x : x - w.half_x;
            cy = c[1] ? y + w.half_y : y - w.half_y;
            cz = c[2] ? z + w.half_z : z - w.half_z;
            r.inside_res = point_inside(cx, cy, cz);
          end
        end
      endcase
    end
    r.planes_ready = pln_ok;
    return r;
  endfunction

  // Send one word; the word is taken at the first edge with busy low.
  // Start stays high after the word is taken, so the next call drives on.
  task automatic send_word(in_word_t w);
    if (idle_on && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
    expected_q.push_back(cull_predict(w));
  endtask

  function automatic in_word_t load_word(int idx, int val);
    in_word_t w;
    w = '0;
    w.command    = CMD_LOAD;
    w.elem_index = 4'(idx);
    w.elem_value = val;
    w.pos_x      = $urandom;
    w.radius     = 31'($urandom);
    return w;
  endfunction

  function automatic in_word_t test_word(cmd_t cmd, int x, int y, int z,
                                         int rad, int hx, int hy, int hz);
    in_word_t w;
    w.command    = cmd;
    w.elem_index = 4'($urandom);
    w.elem_value = $urandom;
    w.pos_x = x; w.pos_y = y; w.pos_z = z;
    w.radius = 31'(rad); w.half_x = 31'(hx); w.half_y = 31'(hy); w.half_z = 31'(hz);
    return w;
  endfunction

  function automatic int rand_small(int mag);
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  // Every result is checked against the oldest expectation.
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_q.size() == 0) begin
        fails++;
        if (mismatches++ < 10) $display("unexpected result word %b", out_word);
      end else begin
        out_word_t e;
        e = expected_q.pop_front();
        if (out_word.inside_res !== e.inside_res ||
            out_word.planes_ready !== e.planes_ready) begin
          fails++;
          if (mismatches++ < 10)
            $display("mismatch: expected inside=%b ready=%b, got inside=%b ready=%b",
                     e.inside_res, e.planes_ready, out_word.inside_res,
                     out_word.planes_ready);
        end
      end
    end
  end

  // Watchdog on cycles where no word moves in either direction.
  always @(negedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_before_planes();
    send_word(test_word(CMD_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_word(test_word(CMD_SPHERE, 0, 0, 0, 31'h7fffffff, 0, 0, 0));
    send_word(test_word(CMD_BOX, 0, 0, 0, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
  endtask

  // An all-zero matrix gives planes with zero length, stored as zero.
  task automatic test_degenerate_planes();
    send_word(load_word(15, 0));
    send_word(test_word(CMD_POINT, 65536, 0, 0, 0, 0, 0, 0));
    send_word(test_word(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    send_word(test_word(CMD_SPHERE, 0, 0, 0, 1, 0, 0, 0));
    send_word(test_word(CMD_BOX, 0, 0, 0, 0, 65536, 65536, 65536));
  endtask

  // Extreme matrix entries saturate the planes; extreme positions saturate
  // the distances, and corners run past 32 bits.
  task automatic test_extremes();
    for (int i = 0; i < 16; i++)
      send_word(load_word(i, (i % 3 == 0) ? 32'h7fffffff : 32'h80000000));
    send_word(test_word(CMD_POINT, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0));
    send_word(test_word(CMD_SPHERE, 32'h80000000, 32'h80000000, 32'h80000000,
                        31'h7fffffff, 0, 0, 0));
    send_word(test_word(CMD_BOX, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0,
                        31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    send_word(load_word(3, 0));
    send_word(test_word(CMD_POINT, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random();
    int val;
    int order [16];
    for (int m = 0; m < 20; m++) begin
      idle_on = !(m >= 8 && m < 12);
      // Mostly small random matrices, mostly loaded in order, some noise.
      for (int i = 0; i < 16; i++) order[i] = i;
      if ($urandom_range(3) == 0) order.shuffle();
      for (int i = 0; i < 16; i++) begin
        if (order[i] == 15) continue;
        val = ($urandom_range(9) == 0) ? int'($urandom) : rand_small(4 << FB);
        send_word(load_word(order[i], val));
      end
      send_word(load_word(15, ($urandom_range(9) == 0) ? int'($urandom)
                                                         : rand_small(4 << FB)));
      for (int t = 0; t < 75; t++) begin
        cmd_t c;
        int   span;
        c    = cmd_t'($urandom_range(1, 3));
        span = ($urandom_range(7) == 0) ? 32'h7fffffff : (8 << FB);
        if ($urandom_range(19) == 0) begin
          send_word(load_word($urandom_range(14), $urandom));
        end else if (span == 32'h7fffffff) begin
          send_word(test_word(c, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom));
        end else begin
          send_word(test_word(c, rand_small(span), rand_small(span), rand_small(span),
                              $urandom_range(4 << FB), $urandom_range(4 << FB),
                              $urandom_range(4 << FB), $urandom_range(4 << FB)));
        end
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_word      = '0;
    pln_ok       = 1'b0;
    mismatches   = 0;
    fails        = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    foreach (mtx[i]) mtx[i] = 0;
    foreach (pln[i]) pln[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_planes();
    test_degenerate_planes();
    test_extremes();
    test_random();
    start <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
